### rtl/dvl_pkg.sv
// ----------------------------------------------------------------------------
// dvl_pkg
// Types, constants and elaboration-time table builders for the delayed
// vibrato LFO.
// ----------------------------------------------------------------------------
package dvl_pkg;

    localparam int FREQ_W     = 32;
    localparam int WAIT_W     = 19;
    localparam int DEPTH_W    = 11;
    localparam int STEP_W     = 28;
    localparam int SINE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;
    localparam int GAIN_W     = 31;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = 4;
    localparam int PROD_W     = 63;
    localparam int X_W        = 28;
    localparam int Q_W        = 18;
    localparam int U_W        = 19;
    localparam int EXP_INT_W  = 3;
    localparam int SHIFT_W    = 6;
    localparam int RND_W      = 37;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CENTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd2;

    localparam logic [WAIT_W-1:0]  WAIT_SAMPLES_RST = 19'd8820;
    localparam logic [DEPTH_W-1:0] DEPTH_CENTS_RST  = 11'd24;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST   = 28'd36524;

    // x = s*depth + 300 + 600*2^17, kept nonnegative: with the sine offset
    // by 2^15 this becomes s_off*depth + DEPTH_BIAS - depth*2^15.
    localparam logic [26:0]       DEPTH_BIAS  = 27'd78643500;
    // floor(x/600) = floor((x>>3) * RECIP_75 / 2^32), exact for x < 2^28
    localparam logic [31:0]       RECIP_75    = 32'd57266231;
    // exponent offset: u = e + 4*2^16 = q + 2^17
    localparam logic [U_W-1:0]    EXP_OFFSET  = 19'd131072;
    localparam logic [63:0]       HALF_Q30    = 64'd536870912;
    localparam logic [GAIN_W-1:0] ONE_Q30     = 31'd1073741824;
    // shift = 30 - n = 34 - exp_int
    localparam logic [SHIFT_W-1:0] SHIFT_BASE = 6'd34;
    localparam longint unsigned   HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEPTH,
        ST_RECIP,
        ST_EXP,
        ST_FREQ,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic [WAIT_W-1:0]  wait_samples;
        logic [DEPTH_W-1:0] depth_cents;
        logic [STEP_W-1:0]  phase_step;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] c;
    } mac_req_t;

    typedef logic [FRAC_W-1:0][31:0] exp2_tbl_t;

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry at bit position p of the exponent fraction is 2^(2^-(16-p)) in Q30
    function automatic exp2_tbl_t build_exp2_tbl();
        exp2_tbl_t tbl;
        longint unsigned root;
        root = 64'h8000_0000;
        for (int k = 1; k <= FRAC_W; k++) begin
            root = isqrt64(root << 30);
            tbl[FRAC_W-k] = root[31:0];
        end
        return tbl;
    endfunction

    localparam exp2_tbl_t EXP2_TBL = build_exp2_tbl();

    // Q1.15 sine sample idx of a 2^aw entry table: quarter-wave fold,
    // Q30 Taylor series, round half up, cap at full scale
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned aw);
        longint unsigned depth;
        longint unsigned t;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned y;
        longint unsigned ang;
        longint unsigned x2;
        longint unsigned term;
        longint          s;
        longint          q;
        depth = 64'd1 << aw;
        t     = 64'(idx) << 2;
        quad  = t >> aw;
        r     = t & (depth - 64'd1);
        y     = quad[0] ? depth - r : r;
        ang   = (y * HALF_PI_Q30 + (depth >> 1)) >> aw;
        x2    = (ang * ang) >> 30;
        term  = ang;
        s     = longint'(ang);
        term  = ((term * x2) >> 30) / 64'd6;
        s     = s - longint'(term);
        term  = ((term * x2) >> 30) / 64'd20;
        s     = s + longint'(term);
        term  = ((term * x2) >> 30) / 64'd42;
        s     = s - longint'(term);
        term  = ((term * x2) >> 30) / 64'd72;
        s     = s + longint'(term);
        term  = ((term * x2) >> 30) / 64'd110;
        s     = s - longint'(term);
        term  = ((term * x2) >> 30) / 64'd156;
        s     = s + longint'(term);
        term  = ((term * x2) >> 30) / 64'd210;
        s     = s - longint'(term);
        if (s < 0) begin
            s = 0;
        end
        q = (s + 64'sd16384) >>> 15;
        if (q > 64'sd32767) begin
            q = 64'sd32767;
        end
        if (quad >= 64'd2) begin
            q = -q;
        end
        return q[SINE_W-1:0];
    endfunction

endpackage

### rtl/delayed_vibrato_lfo_unit.sv
// ----------------------------------------------------------------------------
// delayed_vibrato_lfo_unit
// Delayed sine vibrato on a Q16.16 oscillator frequency stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: tdata is the frequency, tuser
//   set marks a note start, which clears the phase and the wait counter
//   and produces no result. Every other item produces exactly one result
//   on m_axis. cfg writes the wait, depth and phase step registers; write
//   them only while the block is idle. cfg_ready is always high.
//   A pass-through item (wait counter still below the wait register)
//   shows its result in the cycle after the transfer. A vibrato item
//   runs through depth scaling, division by 600, one exp2 factor per
//   set bit of the 16-bit exponent fraction and the frequency multiply,
//   all on the single shared multiplier, then the rounding step, which
//   uses no multiply. One item is in flight at a time.
//   The result sits in an output register; s_axis_tready stays low while
//   it waits to be taken. Reset clears phase, wait counter and pending
//   output and restores the register defaults; the sine table is constant.
// ----------------------------------------------------------------------------
module delayed_vibrato_lfo_unit
    import dvl_pkg::*;
#(
    parameter int TABLE_DEPTH     = 4096,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [FREQ_W-1:0]     s_axis_tdata,  // [31:0] orig_freq
    input  logic                  s_axis_tuser,  // [0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [FREQ_W-1:0]     m_axis_tdata,  // [31:0] out_freq
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [WAIT_W-1:0]  wait_samples_reg;
    logic [DEPTH_W-1:0] depth_cents_reg;
    logic [STEP_W-1:0]  phase_step_reg;
    cfg_t               cfg;
    logic [ADDR_W-1:0]  rom_addr;
    logic [SINE_W-1:0]  rom_data;
    mac_req_t           mac_req;
    logic [63:0]        mac_p;

    assign cfg_ready = 1'b1;

    // unknown index: drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wait_samples_reg <= WAIT_SAMPLES_RST;
            depth_cents_reg  <= DEPTH_CENTS_RST;
            phase_step_reg   <= PHASE_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WAIT_SAMPLES: wait_samples_reg <= cfg_data[WAIT_W-1:0];
                CFG_DEPTH_CENTS:  depth_cents_reg  <= cfg_data[DEPTH_W-1:0];
                CFG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.wait_samples = wait_samples_reg;
    assign cfg.depth_cents  = depth_cents_reg;
    assign cfg.phase_step   = phase_step_reg;

    dvl_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    dvl_mac u_mac (
        .req (mac_req),
        .p   (mac_p)
    );

    dvl_ctrl #(
        .ADDR_W          (ADDR_W),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_func   (s_axis_tuser),
        .s_freq   (s_axis_tdata),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .rom_addr (rom_addr),
        .rom_data (rom_data),
        .mac_req  (mac_req),
        .mac_p    (mac_p)
    );

endmodule

### rtl/dvl_sine_rom.sv
// ----------------------------------------------------------------------------
// dvl_sine_rom
// Full-cycle Q1.15 sine table with a registered read port.
// ----------------------------------------------------------------------------
module dvl_sine_rom
    import dvl_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           clk,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    output logic [SINE_W-1:0]              data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [SINE_W-1:0] rom [TABLE_DEPTH];
    logic [SINE_W-1:0] data_reg;

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
        assign rom[gi] = sine_entry(gi, ADDR_W);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

### rtl/dvl_mac.sv
// ----------------------------------------------------------------------------
// dvl_mac
// Shared unsigned 32x32 multiplier with a 64-bit addend.
// ----------------------------------------------------------------------------
module dvl_mac
    import dvl_pkg::*;
(
    input  mac_req_t    req,
    output logic [63:0] p
);

    assign p = ({32'b0, req.a} * {32'b0, req.b}) + req.c;

endmodule

### rtl/dvl_ctrl.sv
// ----------------------------------------------------------------------------
// dvl_ctrl
// Sequencer and datapath registers: pass-through counting, exponent
// computation, exp2 product loop, final scaling and phase advance.
// ----------------------------------------------------------------------------
module dvl_ctrl
    import dvl_pkg::*;
#(
    parameter int ADDR_W          = 12,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [FREQ_W-1:0] s_freq,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [FREQ_W-1:0] m_data,
    output logic [ADDR_W-1:0] rom_addr,
    input  logic [SINE_W-1:0] rom_data,
    output mac_req_t          mac_req,
    input  logic [63:0]       mac_p
);

    localparam int PHASE_W = ADDR_W + PHASE_FRAC_BITS;
    localparam int SUM_W   = (PHASE_W > STEP_W) ? PHASE_W : STEP_W;

    state_t                 state_reg,     state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]      out_data_reg,  out_data_next;
    logic [PHASE_W-1:0]     phase_reg,     phase_next;
    logic [WAIT_W-1:0]      wait_reg,      wait_next;
    logic [FREQ_W-1:0]      freq_reg,      freq_next;
    logic [X_W-1:0]         x_reg,         x_next;
    logic [FRAC_W-1:0]      f_reg,         f_next;
    logic [EXP_INT_W-1:0]   exp_int_reg,   exp_int_next;
    logic [GAIN_W-1:0]      g_reg,         g_next;
    logic [PROD_W-1:0]      prod_reg,      prod_next;

    logic                   out_free;
    logic [POS_W-1:0]       top_pos;
    logic [FRAC_W-1:0]      f_clear;
    logic [U_W-1:0]         u_sum;
    logic [SUM_W-1:0]       phase_sum;
    logic [SHIFT_W-1:0]     shift_amt;
    logic [PROD_W-1:0]      shifted;
    logic                   round_bit;
    logic [RND_W-1:0]       rnd;
    logic                   sat;

    assign rom_addr = phase_reg[PHASE_W-1 -: ADDR_W];
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // highest set bit of the remaining exponent fraction goes first
    always_comb
    begin
        top_pos = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (f_reg[i]) begin
                top_pos = POS_W'(i);
            end
        end
    end

    assign f_clear   = f_reg & ~(FRAC_W'(1) << top_pos);
    assign u_sum     = U_W'(mac_p[32 +: Q_W]) + EXP_OFFSET;
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(cfg.phase_step);
    assign shift_amt = SHIFT_BASE - SHIFT_W'(exp_int_reg);
    assign shifted   = prod_reg >> shift_amt;
    assign round_bit = prod_reg[shift_amt - SHIFT_W'(1)];
    assign rnd       = {1'b0, shifted[RND_W-2:0]} + RND_W'(round_bit);
    assign sat       = |rnd[RND_W-1:FREQ_W];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        freq_next      = freq_reg;
        x_next         = x_reg;
        f_next         = f_reg;
        exp_int_next   = exp_int_reg;
        g_next         = g_reg;
        prod_next      = prod_reg;
        mac_req        = '0;
        s_ready        = 1'b0;
        out_free       = !out_valid_reg || m_ready;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    if (s_func) begin
                        phase_next = '0;
                        wait_next  = '0;
                    end else if (wait_reg < cfg.wait_samples) begin
                        wait_next      = wait_reg + WAIT_W'(1);
                        out_valid_next = 1'b1;
                        out_data_next  = s_freq;
                    end else begin
                        freq_next  = s_freq;
                        state_next = ST_DEPTH;
                    end
                end
            end
            ST_DEPTH:
            begin
                // sine offset to unsigned, bias keeps the sum nonnegative
                mac_req.a  = {16'b0, ~rom_data[SINE_W-1], rom_data[SINE_W-2:0]};
                mac_req.b  = 32'(cfg.depth_cents);
                mac_req.c  = 64'(DEPTH_BIAS - 27'({cfg.depth_cents, 15'b0}));
                x_next     = mac_p[X_W-1:0];
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                mac_req.a    = 32'(x_reg[X_W-1:3]);
                mac_req.b    = RECIP_75;
                f_next       = u_sum[FRAC_W-1:0];
                exp_int_next = u_sum[U_W-1:FRAC_W];
                g_next       = ONE_Q30;
                state_next   = (u_sum[FRAC_W-1:0] == '0) ? ST_FREQ : ST_EXP;
            end
            ST_EXP:
            begin
                mac_req.a = 32'(g_reg);
                mac_req.b = EXP2_TBL[top_pos];
                mac_req.c = HALF_Q30;
                g_next    = mac_p[30 +: GAIN_W];
                f_next    = f_clear;
                if (f_clear == '0) begin
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ:
            begin
                mac_req.a  = freq_reg;
                mac_req.b  = 32'(g_reg);
                prod_next  = mac_p[PROD_W-1:0];
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = sat ? '1 : rnd[FREQ_W-1:0];
                    phase_next     = phase_sum[PHASE_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            wait_reg      <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        freq_reg     <= freq_next;
        x_reg        <= x_next;
        f_reg        <= f_next;
        exp_int_reg  <= exp_int_next;
        g_reg        <= g_next;
        prod_reg     <= prod_next;
    end

endmodule

### rtl/dvl_checker.sv
// ----------------------------------------------------------------------------
// dvl_checker
// Port-level checks on the delayed vibrato LFO, bound to the top level.
// ----------------------------------------------------------------------------
module dvl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while result pending");

    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("note start produced a result");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser
        |=> m_axis_tvalid || !s_axis_tready)
        else $error("sample neither answered nor in progress");

endmodule

bind delayed_vibrato_lfo_unit dvl_checker u_dvl_checker (.*);
